### rtl/core/jkv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_pkg: shared types and constants of the json key/value extractor
// Character codes, result kinds, command format between the front and back
// halves, and the whitespace helper used by the scanner.
// ----------------------------------------------------------------------------
package jkv_pkg;

    localparam int MAX_KEY_CHARS_DEF    = 8;
    localparam int SPACE_HOLD_DEPTH_DEF = 16;
    localparam int CMD_QUEUE_DEPTH      = 4;

    localparam int KEY_BYTES_W = 64;
    localparam int KEY_LEN_W   = 4;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 1'd1;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BRACE  = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_COLON,
        PH_SKIP,
        PH_QUOTED,
        PH_UNQUOTED,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_NOTFOUND = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    // primary action of one command
    typedef enum logic [1:0] {
        OP_NONE,
        OP_HOLD,
        OP_BYTE
    } t_op;

    // one command per input item that causes work in the back half
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       term_valid;
        t_kind      term;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FLUSH,
        BK_BYTE,
        BK_TERM
    } t_back_state;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage
`default_nettype wire

### rtl/core/jkv_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_if: channel interfaces of the json key/value extractor
// Text input, result output and register write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface jkv_text_if ();
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jkv_result_if ();
    logic       valid;
    logic       ready;
    logic [7:0] value_byte;
    logic [1:0] kind;
    logic       last_of_run;

    modport source (output valid, output value_byte, output kind, output last_of_run,
                    input ready);
    modport sink   (input valid, input value_byte, input kind, input last_of_run,
                    output ready);
endinterface

interface jkv_cfg_if import jkv_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [KEY_BYTES_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/jkv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_ram: generic single-write, single-read ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module jkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                    i_wdata,
    input  wire logic                                i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/core/jkv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_front: text scanner
// Holds the key registers, matches the quoted key in a sliding window,
// tracks the parse phase and issues back-end commands from the text.
// ----------------------------------------------------------------------------
module jkv_front import jkv_pkg::*; #(
    parameter int MAX_KEY_CHARS    = MAX_KEY_CHARS_DEF,
    parameter int SPACE_HOLD_DEPTH = SPACE_HOLD_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    jkv_text_if.sink  i_text,
    jkv_cfg_if.sink   i_cfg,
    input  wire logic i_q_full,
    output      logic o_push,
    output      t_cmd o_cmd
);

    localparam int WIN_DEPTH = MAX_KEY_CHARS + 2;
    localparam int LEN_W     = $clog2(MAX_KEY_CHARS + 1);
    localparam int CNT_W     = $clog2(SPACE_HOLD_DEPTH + 1);

    logic [KEY_BYTES_W-1:0] r_key_bytes;
    logic [KEY_LEN_W-1:0]   r_key_len;
    logic [7:0]             r_win [WIN_DEPTH];
    logic [7:0]             n_win [WIN_DEPTH];
    logic [7:0]             w_shift [WIN_DEPTH];
    t_phase                 r_phase, n_phase;
    logic                   r_esc, n_esc;
    logic [CNT_W-1:0]       r_cnt, n_cnt;

    logic [LEN_W-1:0]       len_eff;
    logic [MAX_KEY_CHARS:0] len_hit;
    logic                   needle;
    logic                   accept;
    logic                   unq;
    logic [7:0]             c;
    logic                   last;
    t_cmd                   cmd;

    assign i_cfg.ready  = 1'b1;
    assign i_text.ready = !i_q_full;
    assign accept       = i_text.valid && !i_q_full;
    assign c            = i_text.text_byte;
    assign last         = i_text.end_of_text;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes <= '0;
            r_key_len   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_KEY_BYTES:  r_key_bytes <= i_cfg.data;
                CFG_KEY_LENGTH: r_key_len   <= i_cfg.data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // long keys count as the maximum length
    assign len_eff = (r_key_len > KEY_LEN_W'(MAX_KEY_CHARS)) ? LEN_W'(MAX_KEY_CHARS)
                                                              : r_key_len[LEN_W-1:0];

    always_comb begin
        w_shift[0] = c;
        for (int j = 1; j < WIN_DEPTH; j++) begin
            w_shift[j] = r_win[j-1];
        end
    end

    // one match flag per possible key length, then pick the configured one
    always_comb begin
        for (int l = 0; l <= MAX_KEY_CHARS; l++) begin
            len_hit[l] = (w_shift[l+1] == CH_QUOTE);
            for (int i = 0; i < l; i++) begin
                if (w_shift[l-i] != r_key_bytes[8*i +: 8]) begin
                    len_hit[l] = 1'b0;
                end
            end
        end
        needle = (w_shift[0] == CH_QUOTE) && len_hit[len_eff];
    end

    always_comb begin
        n_win          = r_win;
        n_phase        = r_phase;
        n_esc          = r_esc;
        n_cnt          = r_cnt;
        unq            = 1'b0;
        cmd.op         = OP_NONE;
        cmd.data       = c;
        cmd.term_valid = 1'b0;
        cmd.term       = KIND_DONE;

        case (r_phase)
            PH_SEARCH: begin
                n_win = w_shift;
                if (needle) begin
                    n_phase = PH_COLON;
                end
            end
            PH_COLON: begin
                if (c == CH_COLON) begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (!is_space(c)) begin
                    if (c == CH_QUOTE) begin
                        n_phase = PH_QUOTED;
                    end else begin
                        unq = 1'b1;
                    end
                end
            end
            PH_UNQUOTED: begin
                unq = 1'b1;
            end
            PH_QUOTED: begin
                if (r_esc) begin
                    n_esc  = 1'b0;
                    cmd.op = OP_BYTE;
                end else if (c == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (c == CH_QUOTE) begin
                    cmd.term_valid = 1'b1;
                    cmd.term       = KIND_DONE;
                    n_phase        = PH_DONE;
                end else begin
                    cmd.op = OP_BYTE;
                end
            end
            PH_DONE: ;
            default: ;
        endcase

        if (unq) begin
            n_phase = PH_UNQUOTED;
            if ((c == CH_COMMA) || (c == CH_BRACE)) begin
                n_cnt          = '0;
                cmd.term_valid = 1'b1;
                cmd.term       = KIND_DONE;
                n_phase        = PH_DONE;
            end else if (is_space(c)) begin
                if (r_cnt >= CNT_W'(SPACE_HOLD_DEPTH)) begin
                    n_cnt          = '0;
                    cmd.term_valid = 1'b1;
                    cmd.term       = KIND_OVERFLOW;
                    n_phase        = PH_DONE;
                end else begin
                    cmd.op = OP_HOLD;
                    n_cnt  = r_cnt + CNT_W'(1);
                end
            end else begin
                cmd.op = OP_BYTE;
                n_cnt  = '0;
            end
            // text ends inside the value: trailing space is dropped
            if (last && (n_phase == PH_UNQUOTED)) begin
                if (cmd.op == OP_HOLD) begin
                    cmd.op = OP_NONE;
                end
                n_cnt          = '0;
                cmd.term_valid = 1'b1;
                cmd.term       = KIND_DONE;
                n_phase        = PH_DONE;
            end
        end

        if (last) begin
            if (n_phase != PH_DONE) begin
                cmd.term_valid = 1'b1;
                cmd.term       = KIND_NOTFOUND;
            end
            for (int j = 0; j < WIN_DEPTH; j++) begin
                n_win[j] = '0;
            end
            n_phase = PH_SEARCH;
            n_esc   = 1'b0;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < WIN_DEPTH; j++) begin
                r_win[j] <= '0;
            end
            r_phase <= PH_SEARCH;
            r_esc   <= 1'b0;
            r_cnt   <= '0;
        end else if (accept) begin
            r_win   <= n_win;
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_cnt   <= n_cnt;
        end
    end

    assign o_push = accept && ((cmd.op != OP_NONE) || cmd.term_valid);
    assign o_cmd  = cmd;

endmodule
`default_nettype wire

### rtl/core/jkv_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_cmd_queue: command queue between scanner and emitter
// Small flip-flop fifo so the two halves stall independently.
// ----------------------------------------------------------------------------
module jkv_cmd_queue import jkv_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output      logic o_full,
    output      logic o_valid,
    output      t_cmd o_cmd,
    input  wire logic i_pop
);

    localparam int PW = $clog2(CMD_QUEUE_DEPTH);

    t_cmd          r_slot [CMD_QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == (PW+1)'(CMD_QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/core/jkv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_back: result emitter
// Executes commands: stores held whitespace in a ram, flushes it ahead of
// the next value byte, and emits value bytes and status items through an
// output register.
// ----------------------------------------------------------------------------
module jkv_back import jkv_pkg::*; #(
    parameter int SPACE_HOLD_DEPTH = SPACE_HOLD_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_valid,
    input  wire t_cmd     i_q_cmd,
    output      logic     o_pop,
    jkv_result_if.source  o_result
);

    localparam int CNT_W = $clog2(SPACE_HOLD_DEPTH + 1);
    localparam int AW    = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;

    t_back_state      r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [AW-1:0]    r_idx, n_idx;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    t_kind            r_out_kind;
    logic             r_out_last;

    logic             out_free;
    logic             load;
    logic [7:0]       ld_byte;
    t_kind            ld_kind;
    logic             ld_last;

    logic             we;
    logic             re;
    logic [AW-1:0]    raddr;
    logic [7:0]       rdata;

    jkv_ram #(
        .WIDTH (8),
        .DEPTH (SPACE_HOLD_DEPTH)
    ) u_space_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_q_cmd.data),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign out_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        we      = 1'b0;
        re      = 1'b0;
        raddr   = r_idx;
        load    = 1'b0;
        ld_byte = '0;
        ld_kind = KIND_BYTE;
        ld_last = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && ((i_q_cmd.op == OP_HOLD) || out_free)) begin
                    o_pop = 1'b1;
                    n_cmd = i_q_cmd;
                    case (i_q_cmd.op)
                        OP_HOLD: begin
                            we    = 1'b1;
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                        OP_BYTE: begin
                            if (r_cnt != '0) begin
                                // held spaces go out first
                                re      = 1'b1;
                                raddr   = '0;
                                n_idx   = '0;
                                n_state = BK_FLUSH;
                            end else begin
                                load    = 1'b1;
                                ld_byte = i_q_cmd.data;
                                ld_last = !i_q_cmd.term_valid;
                                if (i_q_cmd.term_valid) begin
                                    n_state = BK_TERM;
                                end
                            end
                        end
                        default: begin
                            load    = 1'b1;
                            ld_kind = i_q_cmd.term;
                            ld_last = 1'b1;
                            n_cnt   = '0;
                        end
                    endcase
                end
            end
            BK_FLUSH: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = rdata;
                    if ((CNT_W'(r_idx) + CNT_W'(1)) == r_cnt) begin
                        n_state = BK_BYTE;
                    end else begin
                        re    = 1'b1;
                        raddr = r_idx + AW'(1);
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            BK_BYTE: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = r_cmd.data;
                    ld_last = !r_cmd.term_valid;
                    n_cnt   = '0;
                    n_state = r_cmd.term_valid ? BK_TERM : BK_IDLE;
                end
            end
            BK_TERM: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_kind = r_cmd.term;
                    ld_last = 1'b1;
                    n_cnt   = '0;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= ld_byte;
            r_out_kind <= ld_kind;
            r_out_last <= ld_last;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.value_byte  = r_out_byte;
    assign o_result.kind        = r_out_kind;
    assign o_result.last_of_run = r_out_last;

endmodule
`default_nettype wire

### rtl/core/json_key_value_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_key_value_extractor: find a quoted key in a json text, emit its value
// Scanner front end, command queue and emitter back end.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  i_text     in   valid/ready   text_byte[7:0], end_of_text
//  o_result   out  valid/ready   value_byte[7:0], kind[1:0], last_of_run
//  i_cfg      in   valid/ready   index[0] (0 key_bytes, 1 key_length), data[63:0]
//
//  the scanner takes one text item per cycle while the command queue has room
//  the emitter sends at most one result per cycle while o_result is ready; held
//  spaces go out ahead of the next value byte, a status item after its byte
//  i_cfg.ready is always high; reset is synchronous, active low, no sweep
//  a stalled o_result fills the four-entry queue, then i_text.ready drops
// ----------------------------------------------------------------------------
module json_key_value_extractor import jkv_pkg::*; #(
    parameter int MAX_KEY_CHARS    = MAX_KEY_CHARS_DEF,
    parameter int SPACE_HOLD_DEPTH = SPACE_HOLD_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    jkv_text_if.sink     i_text,
    jkv_cfg_if.sink      i_cfg,
    jkv_result_if.source o_result
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    jkv_front #(
        .MAX_KEY_CHARS    (MAX_KEY_CHARS),
        .SPACE_HOLD_DEPTH (SPACE_HOLD_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (i_text),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    jkv_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    jkv_back #(
        .SPACE_HOLD_DEPTH (SPACE_HOLD_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

### rtl/core/jkv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_checker: port-level checks of the json key/value extractor
// Watches the result channel for stable stalls and well-formed status items.
// ----------------------------------------------------------------------------
module jkv_checker import jkv_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_res_valid,
    input wire logic       i_res_ready,
    input wire logic [7:0] i_res_value_byte,
    input wire logic [1:0] i_res_kind,
    input wire logic       i_res_last
);

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_value_byte)
            && $stable(i_res_kind) && $stable(i_res_last))
        else $error("result changed while stalled");

    a_status_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_kind != KIND_BYTE) |-> (i_res_value_byte == 8'd0))
        else $error("status item carries a nonzero byte");

    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_kind != KIND_BYTE) |-> i_res_last)
        else $error("status item not last of its run");

endmodule

bind json_key_value_extractor jkv_checker u_jkv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_result.valid),
    .i_res_ready      (o_result.ready),
    .i_res_value_byte (o_result.value_byte),
    .i_res_kind       (o_result.kind),
    .i_res_last       (o_result.last_of_run)
);
`default_nettype wire
